// ===== rtl/aesra_pkg.sv =====
// ---------------------------------------------------------------------------
// aesra_pkg: shared types, opcodes and S-box tables
// The opcode codes, the 16-byte block type and the forward and inverse
// S-box tables are built once at elaboration from GF(2^8) arithmetic.
// ---------------------------------------------------------------------------
package aesra_pkg;

  localparam int IN_DATA_W  = 264;  // state, round key, rcon
  localparam int OUT_DATA_W = 128;
  localparam int OP_W       = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ENC      = 3'd0,
    OP_ENC_LAST = 3'd1,
    OP_DEC      = 3'd2,
    OP_DEC_LAST = 3'd3,
    OP_KEYGEN   = 3'd4
  } aes_op_t;

  // byte i at bits 8i+7..8i, byte 4c+r is row r of column c
  typedef logic [15:0][7:0] blk_t;
  typedef logic [255:0][7:0] sbox_tbl_t;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] AFF_CONST = 8'h63;
  localparam int         INV_EXP   = 254;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] aa;
    acc = '0;
    aa  = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ aa;
      aa = xtime(aa);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int k);
    logic [15:0] w;
    w = {v, v} << k;
    rotl8 = w[15:8];
  endfunction

  function automatic sbox_tbl_t build_sbox();
    sbox_tbl_t  tbl;
    logic [7:0] r;
    logic [7:0] base;
    int         e;
    for (int x = 0; x < 256; x++) begin
      r    = 8'd1;
      base = x[7:0];
      e    = INV_EXP;
      while (e != 0) begin
        if (e % 2 == 1) r = gf_mul(r, base);
        base = gf_mul(base, base);
        e    = e / 2;
      end
      if (x == 0) r = 8'd0;
      tbl[x] = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ AFF_CONST;
    end
    build_sbox = tbl;
  endfunction

  function automatic sbox_tbl_t build_inv_sbox();
    sbox_tbl_t fwd;
    sbox_tbl_t tbl;
    fwd = build_sbox();
    tbl = '0;
    for (int x = 0; x < 256; x++) begin
      tbl[fwd[x]] = x[7:0];
    end
    build_inv_sbox = tbl;
  endfunction

  localparam sbox_tbl_t SBOX     = build_sbox();
  localparam sbox_tbl_t INV_SBOX = build_inv_sbox();

endpackage

// ===== rtl/aesra_sub_layer.sv =====
// ---------------------------------------------------------------------------
// aesra_sub_layer: byte substitution over the whole block
// Sixteen table lookups, forward or inverse S-box per the dec select.
// ---------------------------------------------------------------------------
module aesra_sub_layer
  import aesra_pkg::*;
(
  input  blk_t din,
  input  logic dec,
  output blk_t dout
);

  for (genvar i = 0; i < 16; i++) begin : g_byte
    assign dout[i] = dec ? INV_SBOX[din[i]] : SBOX[din[i]];
  end

endmodule

// ===== rtl/aesra_mix.sv =====
// ---------------------------------------------------------------------------
// aesra_mix: MixColumns / InvMixColumns
// Each column is mixed independently with xtime chains.
// ---------------------------------------------------------------------------
module aesra_mix
  import aesra_pkg::*;
(
  input  blk_t din,
  input  logic dec,
  output blk_t dout
);

  always_comb begin
    logic [3:0][7:0] a;
    logic [3:0][7:0] x2;
    logic [3:0][7:0] x4;
    logic [3:0][7:0] x8;
    logic [3:0][7:0] c1;   // coefficient for the own row
    logic [3:0][7:0] c2;   // next row
    logic [3:0][7:0] c3;   // row after
    logic [3:0][7:0] c4;   // last row
    dout = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]  = din[4*c+k];
        x2[k] = xtime(a[k]);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        if (dec) begin
          c1[k] = x8[k] ^ x4[k] ^ x2[k];      // 14
          c2[k] = x8[k] ^ x2[k] ^ a[k];       // 11
          c3[k] = x8[k] ^ x4[k] ^ a[k];       // 13
          c4[k] = x8[k] ^ a[k];               // 9
        end else begin
          c1[k] = x2[k];                      // 2
          c2[k] = x2[k] ^ a[k];               // 3
          c3[k] = a[k];
          c4[k] = a[k];
        end
      end
      for (int r = 0; r < 4; r++) begin
        dout[4*c+r] = c1[r] ^ c2[(r+1)%4] ^ c3[(r+2)%4] ^ c4[(r+3)%4];
      end
    end
  end

endmodule

// ===== rtl/aes_round_and_key_assist.sv =====
// Path: an instruction is captured in the input register, then its result in
// the result register, which drives the output port;
// throughput: one instruction per cycle while the output is not stalled.
// The rate is set by the single round datapath between the two registers.
// Reset (rst_n low, synchronous) empties both stages; payload is not reset.
// ---------------------------------------------------------------------------
// aes_round_and_key_assist: AES round / key-generation assist unit
// One AES round instruction per transfer: encrypt, last encrypt, decrypt,
// last decrypt or key-generation assist on a 128-bit state.
// ---------------------------------------------------------------------------
module aes_round_and_key_assist
  import aesra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] state_low, [127:64] state_high, [191:128] round_key_low,
  // [255:192] round_key_high, [263:256] round_constant
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] opcode
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] result_low, [127:64] result_high
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Stage 1: captured instruction
  logic       s1_vld_r;
  aes_op_t    s1_op_r;
  blk_t       s1_state_r;
  blk_t       s1_key_r;
  logic [7:0] s1_rcon_r;

  // Stage 2: result register feeding the output port
  logic       out_vld_r;
  blk_t       res_r;
  blk_t       res_nxt;

  logic       s2_load;
  logic       in_xfer;

  // Stage 2 takes a new result when it is empty or being drained;
  // stage 1 refills in the same cycle it hands its item on.
  assign s2_load   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s2_load;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r    <= aes_op_t'(in_tuser);
      s1_state_r <= blk_t'(in_tdata[127:0]);
      s1_key_r   <= blk_t'(in_tdata[255:128]);
      s1_rcon_r  <= in_tdata[263:256];
    end
  end

  // ---- round datapath ----
  logic dec;
  blk_t sub_blk;
  blk_t sr_blk;
  blk_t mix_blk;
  blk_t ka_blk;

  // Only the two decrypt opcodes use the inverse tables; key assist is forward.
  assign dec = (s1_op_r == OP_DEC) || (s1_op_r == OP_DEC_LAST);

  aesra_sub_layer u_sub (
    .din  (s1_state_r),
    .dec  (dec),
    .dout (sub_blk)
  );

  // ShiftRows / InvShiftRows: pure rewiring of the substituted block
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) sr_blk[4*c+r] = sub_blk[4*((c+4-r)%4)+r];
        else     sr_blk[4*c+r] = sub_blk[4*((c+r)%4)+r];
      end
    end
  end

  aesra_mix u_mix (
    .din  (sr_blk),
    .dec  (dec),
    .dout (mix_blk)
  );

  // Key assist: SubWord of state words 1 and 3, each plain and rotated,
  // rcon folded into byte 0 of the rotated copies.
  always_comb begin
    for (int w = 0; w < 4; w++) begin
      for (int j = 0; j < 4; j++) begin
        ka_blk[4*w+j] = sub_blk[4*((w < 2) ? 1 : 3) + ((j + (w % 2)) % 4)];
      end
      if (w % 2 == 1) ka_blk[4*w] = ka_blk[4*w] ^ s1_rcon_r;
    end
  end

  always_comb begin
    case (s1_op_r)
      OP_ENC, OP_DEC:           res_nxt = mix_blk ^ s1_key_r;
      OP_ENC_LAST, OP_DEC_LAST: res_nxt = sr_blk ^ s1_key_r;
      OP_KEYGEN:                res_nxt = ka_blk;
      default:                  res_nxt = '0;   // unused opcodes give zero
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s2_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

`ifndef SYNTHESIS
  // Backpressure at the input only when both stages hold an item
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_vld_r && out_vld_r))
    else $error("input stalled with a free stage");

  // Unused opcodes yield an all-zero result
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s1_op_r != OP_ENC && s1_op_r != OP_ENC_LAST && s1_op_r != OP_DEC &&
     s1_op_r != OP_DEC_LAST && s1_op_r != OP_KEYGEN) |=> (out_tdata == '0))
    else $error("unused opcode gave nonzero result");

  // Key assist: word 1 bytes 1..3 are word 0 rotated
  a_keygen_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s1_op_r == OP_KEYGEN) |=> (out_tdata[63:40] == {out_tdata[7:0],
                                                                 out_tdata[31:16]}))
    else $error("key assist rotation mismatch");

  // A result is loaded only from a full input stage
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_vld_r) && $past(rst_n)) |-> $past(s1_vld_r))
    else $error("result appeared without an instruction");
`endif

endmodule
